// ===== hw/rtl/psns_pkg.sv =====
// ----------------------------------------------------------------------------
// Point store nearest search: shared types and constants
// Field widths of the stream words, operation and status codes, and the
// result record that the core assembles before handing it to the output.
// ----------------------------------------------------------------------------
package psns_pkg;

	// Fixed widths of the word fields.
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int COORD_W    = 31;
	localparam int ENTRY_W    = 10;
	localparam int SQ_DIST_W  = 63;
	localparam int COUNT_W    = 11;

	// Stream word widths, padded to whole bytes.
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 152;

	// Operation codes carried in s_tuser.
	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_READ    = 2'd2,
		OP_NEAREST = 2'd3
	} op_t;

	// Status codes carried in m_tuser.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_INDEX = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// One result word.
	typedef struct packed {
		status_t                     status;
		logic [ENTRY_W-1:0]          found_index;
		logic signed [COORD_W-1:0]   point_x;
		logic signed [COORD_W-1:0]   point_y;
		logic [SQ_DIST_W-1:0]        sq_distance;
		logic [COUNT_W-1:0]          point_count;
	} result_t;

endpackage

// ===== hw/rtl/psns_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module psns_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/psns_dist.sv =====
// ----------------------------------------------------------------------------
// Squared distance pipeline
// Three stages: coordinate differences, squares, sum. The index and a valid
// flag travel alongside so the caller can pick the closest point.
// ----------------------------------------------------------------------------
module psns_dist #(
	parameter int COORD_BITS = 31,
	parameter int IDX_W      = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [IDX_W-1:0]            in_idx,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output logic                        out_valid,
	output logic [IDX_W-1:0]            out_idx,
	output logic [2*COORD_BITS:0]       out_dist,
	output logic                        busy
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = 2 * COORD_BITS + 1;

	logic                     vld_s2, vld_s3, vld_s4;
	logic [IDX_W-1:0]         idx_s2, idx_s3, idx_s4;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]          sqx_s3, sqy_s3;
	logic [DIST_W-1:0]        dist_s4;
	logic signed [PROD_W-1:0] sqx_full, sqy_full;

	// A square of a difference is never negative and fits in SQ_W bits.
	always_comb begin
		sqx_full = PROD_W'(dx_s2) * PROD_W'(dx_s2);
		sqy_full = PROD_W'(dy_s2) * PROD_W'(dy_s2);
	end

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= in_valid;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		dx_s2   <= DIFF_W'(qx) - DIFF_W'(px);
		dy_s2   <= DIFF_W'(qy) - DIFF_W'(py);
		idx_s2  <= in_idx;
		sqx_s3  <= sqx_full[SQ_W-1:0];
		sqy_s3  <= sqy_full[SQ_W-1:0];
		idx_s3  <= idx_s2;
		dist_s4 <= DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
		idx_s4  <= idx_s3;
	end

	assign out_valid = vld_s4;
	assign out_idx   = idx_s4;
	assign out_dist  = dist_s4;
	assign busy      = vld_s2 | vld_s3 | vld_s4;

endmodule

// ===== hw/rtl/point_store_nearest_search_core.sv =====
// ----------------------------------------------------------------------------
// Point store with nearest search
// Appends, clears and reads back 2-D points and finds the stored point
// closest to a query position.
// ----------------------------------------------------------------------------
// The core takes one word at a time. Append, clear and a bad read go straight
// to the done state; a good read first captures the registered memory data in
// the read state. A nearest query on a non-empty store scans the stored points:
// the point memory has one read port, so the scan reads one point per cycle,
// then the distance pipeline drains. The first point wins a tie. A finished
// result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module point_store_nearest_search_core
	import psns_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_tdata, from bit 0: coord_x[31], coord_y[31], entry_index[10].
	input  logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser: operation[2].
	input  logic [OP_W-1:0]      s_tuser,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// m_tdata, from bit 0: found_index[10], point_x[31], point_y[31],
	// sq_distance[63], point_count[11], zero pad[6].
	output logic [M_TDATA_W-1:0] m_tdata,
	// m_tuser: status[2].
	output logic [STATUS_W-1:0]  m_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready
);

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CMP_W  = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
	localparam int DIST_W = 2 * COORD_BITS + 1;
	localparam int PAD_W  = M_TDATA_W - (ENTRY_W + 2 * COORD_W + SQ_DIST_W + COUNT_W);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             scan_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	result_t                      res_q;
	result_t                      out_q;
	logic                         out_vld_q;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	logic                         best_vld_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [DIST_W-1:0]            best_dist_q;

	// Input word fields.
	op_t                          in_op;
	logic [COORD_W-1:0]           in_x, in_y;
	logic [ENTRY_W-1:0]           in_idx;
	logic signed [COORD_BITS-1:0] in_cx, in_cy;
	logic                         accept;
	logic                         full;
	logic                         idx_bad;
	logic                         scan_last;

	// Memory and distance pipeline connections.
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr, ram_raddr;
	logic [2*COORD_BITS-1:0]      ram_wdata, ram_rdata;
	logic signed [COORD_BITS-1:0] rd_x, rd_y;
	logic                         d_valid, d_busy;
	logic [IDX_W-1:0]             d_idx;
	logic [DIST_W-1:0]            d_dist;

	always_comb begin
		in_op     = op_t'(s_tuser);
		in_x      = s_tdata[COORD_W-1:0];
		in_y      = s_tdata[2*COORD_W-1:COORD_W];
		in_idx    = s_tdata[2*COORD_W+ENTRY_W-1:2*COORD_W];
		in_cx     = $signed(in_x[COORD_BITS-1:0]);
		in_cy     = $signed(in_y[COORD_BITS-1:0]);
		accept    = s_tvalid && s_tready;
		full      = (count_q == CNT_W'(MAX_POINTS));
		idx_bad   = (CMP_W'(in_idx) >= CMP_W'(count_q));
		scan_last = ((scan_q + CNT_W'(1)) == count_q);
		rd_x      = $signed(ram_rdata[COORD_BITS-1:0]);
		rd_y      = $signed(ram_rdata[2*COORD_BITS-1:COORD_BITS]);
	end

	assign s_tready = (state_q == S_IDLE);

	// Memory port control: appends write at the fill count, reads and scans
	// share the read port.
	always_comb begin
		ram_we    = accept && (in_op == OP_APPEND) && !full;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = {in_cy, in_cx};
		ram_raddr = (state_q == S_SCAN) ? scan_q[IDX_W-1:0] : IDX_W'(in_idx);
	end

	psns_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	psns_dist #(
		.COORD_BITS(COORD_BITS),
		.IDX_W     (IDX_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_vld_s1),
		.in_idx    (rd_idx_s1),
		.qx        (qx_q),
		.qy        (qy_q),
		.px        (rd_x),
		.py        (rd_y),
		.out_valid (d_valid),
		.out_idx   (d_idx),
		.out_dist  (d_dist),
		.busy      (d_busy)
	);

	// Sequencer, fill count and scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= S_DONE;
							end
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							OP_READ: begin
								state_q <= idx_bad ? S_DONE : S_READ;
							end
							OP_NEAREST: begin
								scan_q  <= '0;
								state_q <= (count_q == '0) ? S_DONE : S_SCAN;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: state_q <= S_DONE;
				S_SCAN: begin
					scan_q <= scan_q + CNT_W'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_vld_s1 && !d_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_vld_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Best candidate so far; strict compare keeps the lowest index on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (accept) begin
			best_vld_q <= 1'b0;
		end else if (d_valid) begin
			best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (d_valid && (!best_vld_q || (d_dist < best_dist_q))) begin
			best_idx_q  <= d_idx;
			best_dist_q <= d_dist;
		end
	end

	// Scan index travels with the read data.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[IDX_W-1:0];
	end

	// Result assembly.
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q              <= in_cx;
			qy_q              <= in_cy;
			res_q.status      <= ST_OK;
			res_q.found_index <= '0;
			res_q.point_x     <= '0;
			res_q.point_y     <= '0;
			res_q.sq_distance <= '0;
			res_q.point_count <= COUNT_W'(count_q);
			case (in_op)
				OP_APPEND: begin
					if (full) begin
						res_q.status <= ST_FULL;
					end else begin
						res_q.point_count <= COUNT_W'(count_q + CNT_W'(1));
					end
				end
				OP_CLEAR: res_q.point_count <= '0;
				OP_READ: begin
					res_q.found_index <= in_idx;
					if (idx_bad) begin
						res_q.status <= ST_BAD_INDEX;
					end
				end
				OP_NEAREST: begin
					if (count_q == '0) begin
						res_q.status <= ST_EMPTY;
					end
				end
				default: res_q.status <= ST_OK;
			endcase
		end else if (state_q == S_READ) begin
			res_q.point_x <= COORD_W'(rd_x);
			res_q.point_y <= COORD_W'(rd_y);
		end else if ((state_q == S_DRAIN) && !rd_vld_s1 && !d_busy) begin
			res_q.found_index <= ENTRY_W'(best_idx_q);
			res_q.sq_distance <= SQ_DIST_W'(best_dist_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == S_DONE) && (!out_vld_q || m_tready)) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!out_vld_q || m_tready)) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {
		{PAD_W{1'b0}},
		out_q.point_count,
		out_q.sq_distance,
		out_q.point_y,
		out_q.point_x,
		out_q.found_index
	};

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the point store nearest search core
// Drives append, clear, read and nearest query words into the core and
// predicts each result word from a shadow copy of the point store. Every
// result is checked field by field, in order, against the predictions.
// Sender gaps and receiver stalls are varied phase by phase. The run ends
// with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
	import psns_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 20;
	localparam int STORE_DEPTH  = 1024;
	localparam int LIMIT_CYCLES = 4000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_GAP      = 40;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ENTRY_W-1:0]        entry_t;

	localparam coord_t COORD_MIN = 31'sh4000_0000;
	localparam coord_t COORD_MAX = 31'sh3FFF_FFFF;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [OP_W-1:0]      s_tuser  = OP_APPEND;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;

	// Shadow copy of the point store, updated as words are accepted.
	coord_t shadow_x [STORE_DEPTH];
	coord_t shadow_y [STORE_DEPTH];
	int     shadow_count = 0;

	// Result words still owed by the core, oldest first.
	result_t pending_results [$];

	int error_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;
	int cycle_count;

	point_store_nearest_search_core #(
		.MAX_POINTS(STORE_DEPTH),
		.COORD_BITS(COORD_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Squared distance between two points, computed at full width.
	function automatic longint unsigned squared_span(coord_t ax, coord_t ay,
			coord_t bx, coord_t by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return longint'(dx * dx) + longint'(dy * dy);
	endfunction

	// Applies one operation to the shadow store and returns the result word
	// that the core must produce for it.
	function automatic result_t store_outcome(op_t op, coord_t x, coord_t y,
			entry_t idx);
		result_t          r;
		longint unsigned  span;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_APPEND: begin
				if (shadow_count >= STORE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_x[shadow_count] = x;
					shadow_y[shadow_count] = y;
					shadow_count++;
				end
			end
			OP_CLEAR: begin
				shadow_count = 0;
			end
			OP_READ: begin
				r.found_index = idx;
				if (int'(idx) >= shadow_count) begin
					r.status = ST_BAD_INDEX;
				end else begin
					r.point_x = shadow_x[idx];
					r.point_y = shadow_y[idx];
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// Only a strictly closer point replaces the best one.
					r.sq_distance = squared_span(x, y, shadow_x[0], shadow_y[0]);
					for (int i = 1; i < shadow_count; i++) begin
						span = squared_span(x, y, shadow_x[i], shadow_y[i]);
						if (span < r.sq_distance) begin
							r.sq_distance = span;
							r.found_index = entry_t'(i);
						end
					end
				end
			end
		endcase
		r.point_count = COUNT_W'(shadow_count);
		return r;
	endfunction

	// Sends one word, with a random gap ahead of it, and records what it owes.
	task automatic send_word(op_t op, coord_t x, coord_t y, entry_t idx);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {idx, y, x};
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results = {pending_results, store_outcome(op, x, y, idx)};
	endtask

	// Random coordinate: full range, near the origin, or an extreme value.
	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: return coord_t'(int'($urandom_range(16)) - 8);
			1: begin
				case ($urandom_range(3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return coord_t'(0);
					default: return coord_t'(-1);
				endcase
			end
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Extremes, every operation and the special cases on a small store.
	task automatic test_directed();
		send_word(OP_NEAREST, coord_t'(0), coord_t'(0), entry_t'($urandom));
		send_word(OP_READ, rand_coord(), rand_coord(), entry_t'(0));
		send_word(OP_READ, rand_coord(), rand_coord(), entry_t'(1023));
		send_word(OP_APPEND, COORD_MIN, COORD_MIN, entry_t'($urandom));
		send_word(OP_APPEND, COORD_MAX, COORD_MAX, entry_t'($urandom));
		send_word(OP_APPEND, COORD_MIN, COORD_MAX, entry_t'($urandom));
		send_word(OP_APPEND, COORD_MAX, COORD_MIN, entry_t'($urandom));
		send_word(OP_APPEND, coord_t'(0), coord_t'(0), entry_t'($urandom));
		send_word(OP_READ, rand_coord(), rand_coord(), entry_t'(0));
		send_word(OP_READ, rand_coord(), rand_coord(), entry_t'(4));
		send_word(OP_READ, rand_coord(), rand_coord(), entry_t'(5));
		send_word(OP_NEAREST, COORD_MAX, COORD_MAX, entry_t'($urandom));
		send_word(OP_NEAREST, coord_t'(-1), coord_t'(-1), entry_t'($urandom));
		send_word(OP_CLEAR, rand_coord(), rand_coord(), entry_t'($urandom));
		send_word(OP_READ, rand_coord(), rand_coord(), entry_t'(0));
		send_word(OP_NEAREST, rand_coord(), rand_coord(), entry_t'($urandom));
		// The largest possible distance, corner to corner.
		send_word(OP_APPEND, COORD_MIN, COORD_MIN, entry_t'($urandom));
		send_word(OP_NEAREST, COORD_MAX, COORD_MAX, entry_t'($urandom));
		send_word(OP_CLEAR, rand_coord(), rand_coord(), entry_t'($urandom));
		// Three points at the same distance: the first one must win.
		send_word(OP_APPEND, coord_t'(1), coord_t'(0), entry_t'($urandom));
		send_word(OP_APPEND, coord_t'(-1), coord_t'(0), entry_t'($urandom));
		send_word(OP_APPEND, coord_t'(0), coord_t'(1), entry_t'($urandom));
		send_word(OP_NEAREST, coord_t'(0), coord_t'(0), entry_t'($urandom));
		send_word(OP_CLEAR, rand_coord(), rand_coord(), entry_t'($urandom));
	endtask

	// Random mix that keeps the store small, with reads mostly in range and
	// queries often close to a stored point.
	task automatic test_random_mix(int count);
		int     pick;
		int     slot;
		coord_t qx;
		coord_t qy;
		entry_t idx;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			idx  = entry_t'($urandom);
			qx   = rand_coord();
			qy   = rand_coord();
			if (pick < 42) begin
				send_word(OP_APPEND, qx, qy, idx);
			end else if (pick < 47) begin
				send_word(OP_CLEAR, qx, qy, idx);
			end else if (pick < 72) begin
				if (shadow_count > 0 && $urandom_range(99) < 75)
					idx = entry_t'($urandom_range(shadow_count - 1));
				send_word(OP_READ, qx, qy, idx);
			end else begin
				if (shadow_count > 0 && $urandom_range(99) < 40) begin
					slot = $urandom_range(shadow_count - 1);
					qx = shadow_x[slot] + coord_t'(int'($urandom_range(4)) - 2);
					qy = shadow_y[slot] + coord_t'(int'($urandom_range(4)) - 2);
				end
				send_word(OP_NEAREST, qx, qy, idx);
			end
		end
	endtask

	// The receiver holds off for a long stretch while words keep coming.
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_request = 300;
		for (int n = 0; n < 16; n++) begin
			case (n % 4)
				0, 1: send_word(OP_APPEND, rand_coord(), rand_coord(), entry_t'($urandom));
				2: send_word(OP_READ, rand_coord(), rand_coord(), entry_t'(n / 4));
				default: send_word(OP_NEAREST, rand_coord(), rand_coord(),
					entry_t'($urandom));
			endcase
		end
	endtask

	// Receiver: random stalls, or a hold-off counted down here.
	always @(posedge clk) begin : recv_ready
		int hold_left;
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic check_field(string field_name, longint unsigned expv,
			longint unsigned actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $realtime,
				field_name, expv, actv);
			error_count++;
		end
	endtask

	// Compares each accepted result word with the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t expected;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word: expected none actual %0h/%0h",
					$realtime, m_tuser, m_tdata);
				error_count++;
			end else begin
				expected = pending_results.pop_front();
				check_field("status", expected.status, m_tuser);
				check_field("found_index", expected.found_index, m_tdata[9:0]);
				check_field("point_x", $unsigned(expected.point_x), m_tdata[40:10]);
				check_field("point_y", $unsigned(expected.point_y), m_tdata[71:41]);
				check_field("sq_distance", expected.sq_distance, m_tdata[134:72]);
				check_field("point_count", expected.point_count, m_tdata[145:135]);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++)
			@(posedge clk);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_directed();

		set_idling(0, 0);
		test_random_mix(135);
		set_idling(52, 0);
		test_random_mix(135);
		set_idling(0, 52);
		test_random_mix(135);
		set_idling(29, 29);
		test_random_mix(135);

		test_backpressure();

		// Let the last words drain out of the core.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
